[sv/eis_pkg.sv]
// Shared types, constants and helper functions for the event interval statistics block.
// Used by every module of the block; depends on nothing else.
package eis_pkg;

  localparam logic [2:0] KIND_ITER_BEGIN = 3'd0;
  localparam logic [2:0] KIND_ITER_END   = 3'd1;
  localparam logic [2:0] KIND_STEP_BEGIN = 3'd2;
  localparam logic [2:0] KIND_STEP_END   = 3'd3;
  localparam logic [2:0] KIND_STEP_MARK  = 3'd4;
  localparam logic [2:0] KIND_VALUE_SET  = 3'd5;
  localparam logic [2:0] KIND_VALUE_ADD  = 3'd6;
  localparam logic [2:0] KIND_NONE       = 3'd7;

  localparam logic [15:0] ITER_NONE   = 16'hFFFF;
  localparam logic [47:0] SQRT_SQ_MAX = 48'd3037000499;
  localparam logic [62:0] SQ_MAX      = {63{1'b1}};

  typedef struct packed {
    logic [7:0]         level;
    logic [31:0]        count;
    logic [31:0]        iter_count;
    logic [47:0]        start_sum;
    logic signed [47:0] min_val;
    logic signed [47:0] max_val;
    logic signed [47:0] total;
    logic [62:0]        total_sq;
    logic [15:0]        last_iter;
    logic [47:0]        last_time;
  } step_entry_t;

  typedef struct packed {
    logic [31:0]        count;
    logic [31:0]        iter_count;
    logic signed [47:0] min_val;
    logic signed [47:0] max_val;
    logic signed [47:0] total;
    logic [62:0]        total_sq;
    logic signed [47:0] iter_sum;
    logic [15:0]        last_iter;
  } val_entry_t;

  // Everything the update logic needs to know about the record in flight.
  typedef struct packed {
    logic [2:0]         kind;
    logic [47:0]        t;
    logic signed [47:0] v;
    logic [7:0]         lvl;
    logic [15:0]        iter;
    logic signed [47:0] dur;
    logic               sq_sat;
  } item_t;

  localparam step_entry_t STEP_RESET = '{last_iter: ITER_NONE, default: '0};
  localparam val_entry_t  VAL_RESET  = '{last_iter: ITER_NONE, default: '0};

  function automatic logic [47:0] sat48(input logic [48:0] a);
    logic [47:0] r;
    if (a[48] != a[47]) begin
      r = a[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    end else begin
      r = a[47:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] inc32(input logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  function automatic logic [62:0] add_sq(input logic [62:0] a, input logic [62:0] b);
    logic [63:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[63] ? SQ_MAX : s[62:0];
  endfunction

  // Folds the running per-iteration total of a value entry into its min and max.
  function automatic val_entry_t fold_val(input val_entry_t q);
    val_entry_t r;
    r = q;
    if (q.count == 32'd1 || $signed(q.iter_sum) < $signed(q.min_val)) r.min_val = q.iter_sum;
    if (q.count == 32'd1 || $signed(q.iter_sum) > $signed(q.max_val)) r.max_val = q.iter_sum;
    return r;
  endfunction

endpackage

[sv/event_interval_statistics.sv]
// Event interval statistics engine: top level with control sequencer and the two tables.
// A record is read from its table when taken, then passes the operand, multiply and
// write-back states; write back waits while an earlier result is still held, and the
// next record is taken only after write back. An iteration end then walks the value table, one
// entry per cycle through its single read port. Reset is synchronous; the tables need no
// clearing pass since per-entry valid bits are cleared at once.
module event_interval_statistics #(
  parameter int NUM_IDS = 64,
  parameter int TIME_BITS = 48,
  parameter int VALUE_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         kind,
  input  logic [5:0]         event_id,
  input  logic [47:0]        timestamp,
  input  logic signed [31:0] sample_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         entry_id,
  output logic               is_value_entry,
  output logic               ignored,
  output logic signed [7:0]  entry_level,
  output logic [31:0]        occurrence_count,
  output logic [31:0]        iteration_count,
  output logic signed [47:0] minimum,
  output logic signed [47:0] maximum,
  output logic signed [47:0] total,
  output logic [62:0]        total_squares
);

  localparam int IW = $clog2(NUM_IDS);
  localparam int CW = $clog2(NUM_IDS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_WALK = 3'd4;

  logic [2:0] state;

  // Iteration bookkeeping kept in flip-flops.
  logic [15:0] itn;
  logic [TIME_BITS-1:0] start;
  logic [7:0] nest;

  // The record in flight.
  logic [2:0] kind_q;
  logic [IW-1:0] idx_q;
  logic [TIME_BITS-1:0] t_q;
  logic signed [31:0] v_q;
  logic [7:0] lvl_q;
  logic ign_q;

  // Operand and product registers around the shared squarer.
  logic signed [47:0] dur_q;
  logic [31:0] opnd;
  logic sat_q;
  logic [63:0] prod;

  // Value-table walk at iteration end.
  logic [CW-1:0] walk_cnt;
  logic pend;
  logic [IW-1:0] pend_addr;

  logic accept;
  logic [IW-1:0] idx_new;
  logic [15:0] itn_inc;
  logic [15:0] itn_new;
  logic ign_new;
  logic [7:0] lvl_use;
  logic [TIME_BITS-1:0] ts_m;
  logic [TIME_BITS-1:0] start_eff;
  logic [7:0] nest_new;

  logic [48:0] diff;
  logic signed [47:0] dur;
  logic [47:0] mag;
  logic [31:0] vmag;

  logic upd_go;
  logic is_val;
  logic walk_issue;
  logic walk_wr;

  eis_pkg::step_entry_t step_rd;
  eis_pkg::step_entry_t step_new;
  eis_pkg::step_entry_t step_out;
  eis_pkg::val_entry_t val_rd;
  eis_pkg::val_entry_t val_new;
  eis_pkg::val_entry_t val_out;
  eis_pkg::val_entry_t val_wdata;
  eis_pkg::item_t item;

  logic step_rd_en;
  logic val_rd_en;
  logic [IW-1:0] val_rd_addr;
  logic step_wr_en;
  logic val_wr_en;
  logic [IW-1:0] val_wr_addr;

  assign accept = in_valid && in_ready;
  assign in_ready = state == ST_IDLE;

  // Decode of the incoming record: iteration numbering, discard test, table index.
  // A begin record restarts the iteration clock and the nesting level before it opens
  // step entry 0 like any other step.
  always_comb begin
    idx_new = '0;
    if (kind != eis_pkg::KIND_ITER_BEGIN && kind != eis_pkg::KIND_ITER_END) begin
      for (int k = 0; k < 64; k++) begin
        if (event_id == 6'(k)) begin
          idx_new = IW'(k % NUM_IDS);
        end
      end
    end
    itn_inc = itn + 16'd1;
    if (kind == eis_pkg::KIND_ITER_BEGIN) begin
      itn_new = (itn_inc == eis_pkg::ITER_NONE) ? 16'd1 : itn_inc;
    end else begin
      itn_new = itn;
    end
    ign_new = itn_new == 16'd0 || itn_new == eis_pkg::ITER_NONE;
    lvl_use = (kind == eis_pkg::KIND_ITER_BEGIN) ? 8'd0 : nest;
    ts_m = timestamp[TIME_BITS-1:0];
    start_eff = (kind == eis_pkg::KIND_ITER_BEGIN) ? ts_m : start;
    nest_new = lvl_use;
    if (!ign_new) begin
      case (kind)
        eis_pkg::KIND_ITER_END, eis_pkg::KIND_STEP_END: nest_new = lvl_use - 8'd1;
        eis_pkg::KIND_ITER_BEGIN, eis_pkg::KIND_STEP_BEGIN: nest_new = lvl_use + 8'd1;
        default: nest_new = lvl_use;
      endcase
    end
  end

  // Duration against the entry's last begin or mark, and the squarer operand.
  // Durations whose square cannot fit saturate without multiplying.
  always_comb begin
    diff = {1'b0, 48'(t_q)} - {1'b0, step_rd.last_time};
    dur = eis_pkg::sat48(diff);
    mag = dur[47] ? 48'(-dur) : 48'(dur);
    vmag = v_q[31] ? 32'(-v_q) : 32'(v_q);
  end

  assign is_val = kind_q == eis_pkg::KIND_VALUE_SET || kind_q == eis_pkg::KIND_VALUE_ADD;
  assign upd_go = state == ST_UPD && (!out_valid || out_ready);
  assign walk_issue = state == ST_WALK && walk_cnt != CW'(NUM_IDS);
  assign walk_wr = state == ST_WALK && pend && val_rd.count != 32'd0;

  always_comb begin
    item.kind = kind_q;
    item.t = 48'(t_q);
    item.v = {{16{v_q[31]}}, v_q};
    item.lvl = lvl_q;
    item.iter = itn;
    item.dur = dur_q;
    item.sq_sat = sat_q;
  end

  eis_calc #(
    .VALUE_FRAC_BITS(VALUE_FRAC_BITS)
  ) u_calc (
    .item (item),
    .s_old(step_rd),
    .q_old(val_rd),
    .prod (prod),
    .s_new(step_new),
    .q_new(val_new)
  );

  // Memory port steering: record accesses in normal operation, the walk at iteration end.
  always_comb begin
    step_rd_en = accept && kind != eis_pkg::KIND_NONE;
    val_rd_en = step_rd_en || walk_issue;
    val_rd_addr = (state == ST_WALK) ? walk_cnt[IW-1:0] : idx_new;
    step_wr_en = upd_go && !ign_q && !is_val;
    val_wr_en = (upd_go && !ign_q && is_val) || walk_wr;
    val_wr_addr = walk_wr ? pend_addr : idx_q;
    val_wdata = walk_wr ? eis_pkg::fold_val(val_rd) : val_new;
    step_out = ign_q ? step_rd : step_new;
    val_out = ign_q ? val_rd : val_new;
  end

  eis_mem #(
    .DEPTH  (NUM_IDS),
    .AW     (IW),
    .entry_t(eis_pkg::step_entry_t),
    .RST_VAL(eis_pkg::STEP_RESET)
  ) u_step_mem (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (step_rd_en),
    .rd_addr(idx_new),
    .rd_data(step_rd),
    .wr_en  (step_wr_en),
    .wr_addr(idx_q),
    .wr_data(step_new)
  );

  eis_mem #(
    .DEPTH  (NUM_IDS),
    .AW     (IW),
    .entry_t(eis_pkg::val_entry_t),
    .RST_VAL(eis_pkg::VAL_RESET)
  ) u_val_mem (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (val_rd_en),
    .rd_addr(val_rd_addr),
    .rd_data(val_rd),
    .wr_en  (val_wr_en),
    .wr_addr(val_wr_addr),
    .wr_data(val_wdata)
  );

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      itn <= eis_pkg::ITER_NONE;
      start <= '0;
      nest <= '0;
      out_valid <= 1'b0;
      walk_cnt <= '0;
      pend <= 1'b0;
    end else begin
      // A new result may only be loaded once the previous one is gone or leaving.
      if (upd_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && kind != eis_pkg::KIND_NONE) begin
            itn <= itn_new;
            start <= start_eff;
            nest <= nest_new;
            state <= ST_LOAD;
          end
        end
        ST_LOAD: state <= ST_MUL;
        ST_MUL: state <= ST_UPD;
        ST_UPD: begin
          if (upd_go) begin
            walk_cnt <= '0;
            pend <= 1'b0;
            if (kind_q == eis_pkg::KIND_ITER_END && !ign_q) begin
              state <= ST_WALK;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_WALK: begin
          if (walk_issue) begin
            pend <= 1'b1;
            walk_cnt <= walk_cnt + CW'(1);
          end else begin
            pend <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Payload registers: the record, the squarer pipeline, the walk address and the result.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= kind;
      idx_q <= idx_new;
      t_q <= ts_m - start_eff;
      v_q <= sample_value;
      lvl_q <= lvl_use;
      ign_q <= ign_new;
    end
    if (state == ST_LOAD) begin
      dur_q <= dur;
      sat_q <= !is_val && mag > eis_pkg::SQRT_SQ_MAX;
      if (is_val) begin
        opnd <= vmag;
      end else begin
        opnd <= (mag > eis_pkg::SQRT_SQ_MAX) ? 32'd0 : mag[31:0];
      end
    end
    if (state == ST_MUL) begin
      prod <= {32'd0, opnd} * {32'd0, opnd};
    end
    if (walk_issue) begin
      pend_addr <= walk_cnt[IW-1:0];
    end
    if (upd_go) begin
      entry_id <= 6'(idx_q);
      is_value_entry <= is_val;
      ignored <= ign_q;
      if (is_val) begin
        entry_level <= 8'sd0;
        occurrence_count <= val_out.count;
        iteration_count <= val_out.iter_count;
        minimum <= val_out.min_val;
        maximum <= val_out.max_val;
        total <= val_out.total;
        total_squares <= val_out.total_sq;
      end else begin
        entry_level <= step_out.level;
        occurrence_count <= step_out.count;
        iteration_count <= step_out.iter_count;
        minimum <= step_out.min_val;
        maximum <= step_out.max_val;
        total <= step_out.total;
        total_squares <= step_out.total_sq;
      end
    end
  end

endmodule

[sv/eis_mem.sv]
// Synchronous table memory with one read and one write port and per-entry valid bits.
// Entries never written read as the reset value. Depends on eis_pkg through its types.
module eis_mem #(
  parameter int DEPTH = 64,
  parameter int AW = 6,
  parameter type entry_t = eis_pkg::step_entry_t,
  parameter entry_t RST_VAL = eis_pkg::STEP_RESET
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data
);

  entry_t mem [DEPTH];
  entry_t q;
  logic [DEPTH-1:0] vld;
  logic q_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      q_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        q_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_data = q_vld ? q : RST_VAL;

endmodule

[sv/eis_calc.sv]
// Next-entry computation for one record: step open and close, value set and add.
// Depends on eis_pkg for entry types, kind codes and saturating helpers.
module eis_calc #(
  parameter int VALUE_FRAC_BITS = 16
) (
  input  eis_pkg::item_t       item,
  input  eis_pkg::step_entry_t s_old,
  input  eis_pkg::val_entry_t  q_old,
  input  logic [63:0]          prod,
  output eis_pkg::step_entry_t s_new,
  output eis_pkg::val_entry_t  q_new
);

  localparam logic [63:0] HALF = (64'd1 << VALUE_FRAC_BITS) >> 1;

  logic [48:0] start_sum;
  logic [62:0] step_sq;
  logic [63:0] rounded;
  logic [62:0] val_sq;
  logic fresh;
  logic is_set;
  eis_pkg::val_entry_t qf;

  always_comb begin
    s_new = s_old;
    q_new = q_old;
    start_sum = {1'b0, s_old.start_sum} + {1'b0, item.t};
    step_sq = item.sq_sat ? eis_pkg::SQ_MAX : prod[62:0];
    rounded = (prod + HALF) >> VALUE_FRAC_BITS;
    val_sq = rounded[62:0];
    fresh = q_old.last_iter != item.iter;
    is_set = item.kind == eis_pkg::KIND_VALUE_SET;
    qf = (is_set || fresh) ? eis_pkg::fold_val(q_old) : q_old;
    case (item.kind)
      eis_pkg::KIND_ITER_BEGIN, eis_pkg::KIND_STEP_BEGIN, eis_pkg::KIND_STEP_MARK: begin
        s_new.level = item.lvl;
        if (s_old.last_iter != item.iter) begin
          s_new.last_iter = item.iter;
          s_new.start_sum = start_sum[48] ? {48{1'b1}} : start_sum[47:0];
          s_new.iter_count = eis_pkg::inc32(s_old.iter_count);
        end
        s_new.last_time = item.t;
        s_new.count = eis_pkg::inc32(s_old.count);
      end
      eis_pkg::KIND_ITER_END, eis_pkg::KIND_STEP_END: begin
        if (s_old.last_iter == item.iter) begin
          s_new.total = eis_pkg::sat48({s_old.total[47], s_old.total} +
                                       {item.dur[47], item.dur});
          s_new.total_sq = eis_pkg::add_sq(s_old.total_sq, step_sq);
          if (s_old.count == 32'd1 || $signed(item.dur) > $signed(s_old.max_val)) begin
            s_new.max_val = item.dur;
          end
          if (s_old.count == 32'd1 || $signed(item.dur) < $signed(s_old.min_val)) begin
            s_new.min_val = item.dur;
          end
        end
      end
      eis_pkg::KIND_VALUE_SET, eis_pkg::KIND_VALUE_ADD: begin
        q_new = qf;
        if (fresh) begin
          q_new.last_iter = item.iter;
          q_new.iter_sum = item.v;
          q_new.iter_count = eis_pkg::inc32(qf.iter_count);
          q_new.count = eis_pkg::inc32(qf.count);
        end else if (is_set) begin
          q_new.iter_sum = item.v;
          q_new.count = eis_pkg::inc32(qf.count);
        end else begin
          q_new.iter_sum = eis_pkg::sat48({qf.iter_sum[47], qf.iter_sum} +
                                          {item.v[47], item.v});
        end
        q_new.total = eis_pkg::sat48({qf.total[47], qf.total} + {item.v[47], item.v});
        q_new.total_sq = eis_pkg::add_sq(qf.total_sq, val_sq);
      end
      default: begin
      end
    endcase
  end

endmodule

[sv/eis_checker.sv]
// Port-level checker for the event interval statistics block, bound to its top level.
// Depends on the top level's ports and on eis_pkg for the kind codes.
module eis_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [2:0]         kind,
  input logic               out_valid,
  input logic               out_ready,
  input logic [5:0]         entry_id,
  input logic               is_value_entry,
  input logic signed [7:0]  entry_level,
  input logic [31:0]        occurrence_count
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(entry_id) &&
    $stable(occurrence_count))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind != eis_pkg::KIND_NONE |=> !in_ready)
    else $error("second record taken while one is in flight");

  a_value_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_value_entry |-> entry_level == 8'sd0)
    else $error("value entry reports a nesting level");

endmodule

bind event_interval_statistics eis_checker u_eis_checker (.*);
